>>> hdl/pnc_pkg.sv
package pnc_pkg;

   localparam int IDX_W     = 14;
   localparam int CNT_W     = 14;
   localparam int CUT_W     = 23;
   localparam int RANK_W    = 6;
   localparam int TOTAL_W   = 7;
   localparam int CSR_IDX_W = 2;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_SHARE_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORKER_RANK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WORKER_TOTAL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF       = 2'd3;

   typedef struct packed {
      logic                share_mode;
      logic [RANK_W-1:0]   worker_rank;
      logic [TOTAL_W-1:0]  worker_total;
      logic [CUT_W-1:0]    cut_dist;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIV_INIT,
      ST_DIV,
      ST_BND_MUL,
      ST_BND_SET,
      ST_ROW_CHK,
      ST_ROW_RD,
      ST_ROW_LAT,
      ST_PAIR_RD,
      ST_PAIR_DIFF,
      ST_PAIR_SQ,
      ST_PAIR_CMP,
      ST_ROW_END,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clr_wr;
      logic div_init;
      logic div_step;
      logic bnd_mul;
      logic bnd_set;
      logic row_rd;
      logic row_lat;
      logic pair_rd;
      logic pair_diff;
      logic pair_sq;
      logic pair_cmp;
      logic row_end;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic row_over;
      logic j_over;
      logic j_last;
   } status_type;

endpackage

>>> hdl/pnc_csr.sv
module pnc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [pnc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pnc_pkg::CUT_W-1:0]      csr_wdata,
   output pnc_pkg::cfg_type               cfg
);
   import pnc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SHARE_MODE:   cfg_in.share_mode      = csr_wdata[0];
            CSR_WORKER_RANK:  cfg_in.worker_rank     = csr_wdata[RANK_W-1:0];
            CSR_WORKER_TOTAL: cfg_in.worker_total    = csr_wdata[TOTAL_W-1:0];
            CSR_CUTOFF:       cfg_in.cut_dist        = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.share_mode      <= 1'b1;
         cfg_ff.worker_rank     <= '0;
         cfg_ff.worker_total    <= TOTAL_W'(1);
         cfg_ff.cut_dist        <= CUT_W'(32768);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/pnc_ctrl.sv
module pnc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 run_go,
   input  pnc_pkg::status_type  status,
   output pnc_pkg::cmd_type     cmd,
   output logic                 busy
);
   import pnc_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (run_go) state_in = ST_CLEAR;
         ST_CLEAR:     if (status.clr_last) state_in = ST_DIV_INIT;
         ST_DIV_INIT:  state_in = ST_DIV;
         ST_DIV:       if (status.div_last) state_in = ST_BND_MUL;
         ST_BND_MUL:   state_in = ST_BND_SET;
         ST_BND_SET:   state_in = ST_ROW_CHK;
         ST_ROW_CHK:   state_in = status.row_over ? ST_DONE : ST_ROW_RD;
         ST_ROW_RD:    state_in = ST_ROW_LAT;
         ST_ROW_LAT:   state_in = status.j_over ? ST_ROW_END : ST_PAIR_RD;
         ST_PAIR_RD:   state_in = ST_PAIR_DIFF;
         ST_PAIR_DIFF: state_in = ST_PAIR_SQ;
         ST_PAIR_SQ:   state_in = ST_PAIR_CMP;
         ST_PAIR_CMP:  state_in = status.j_last ? ST_ROW_END : ST_PAIR_RD;
         ST_ROW_END:   state_in = ST_ROW_CHK;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE:      busy = 1'b0;
         ST_CLEAR:     cmd.clr_wr = 1'b1;
         ST_DIV_INIT:  cmd.div_init = 1'b1;
         ST_DIV:       cmd.div_step = 1'b1;
         ST_BND_MUL:   cmd.bnd_mul = 1'b1;
         ST_BND_SET:   cmd.bnd_set = 1'b1;
         ST_ROW_CHK:   cmd = '0;
         ST_ROW_RD:    cmd.row_rd = 1'b1;
         ST_ROW_LAT:   cmd.row_lat = 1'b1;
         ST_PAIR_RD:   cmd.pair_rd = 1'b1;
         ST_PAIR_DIFF: cmd.pair_diff = 1'b1;
         ST_PAIR_SQ:   cmd.pair_sq = 1'b1;
         ST_PAIR_CMP:  cmd.pair_cmp = 1'b1;
         ST_ROW_END:   cmd.row_end = 1'b1;
         ST_DONE:      cmd.done = 1'b1;
         default:      busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_cmp_after_sq: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAIR_CMP |-> $past(state_ff) == ST_PAIR_SQ)
      else $error("pair compare not preceded by squaring");
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> state_ff == ST_IDLE)
      else $error("run end did not return to idle");
   a_busy_from_go: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(run_go))
      else $error("busy rose without a final load");
`endif

endmodule

>>> hdl/pnc_dp.sv
module pnc_dp #(
   parameter int MAX_ATOMS  = 16384,
   parameter int COORD_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pnc_pkg::cfg_type                   cfg,
   input  pnc_pkg::cmd_type                   cmd,
   output pnc_pkg::status_type                status,
   input  logic                               load_acc,
   input  logic                               read_acc,
   input  logic                               run_go,
   input  logic signed [COORD_BITS-1:0]       pos_x,
   input  logic signed [COORD_BITS-1:0]       pos_y,
   input  logic signed [COORD_BITS-1:0]       pos_z,
   input  logic [pnc_pkg::IDX_W-1:0]          read_index,
   output logic                               rsp_valid,
   output logic [pnc_pkg::IDX_W-1:0]          rsp_atom_index,
   output logic [pnc_pkg::CNT_W-1:0]          rsp_neighbour_count,
   output logic                               rsp_run_done
);
   import pnc_pkg::*;

   localparam int AW  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int NW  = $clog2(MAX_ATOMS + 1);
   localparam int IW  = NW + 1;
   localparam int XW  = (NW > IDX_W) ? NW : IDX_W;
   localparam int CB  = COORD_BITS;
   localparam int MW  = (CB + 1 > CUT_W) ? CB + 1 : CUT_W;
   localparam int SQW = 2 * CUT_W;
   localparam int SMW = SQW + 2;
   localparam int RW  = TOTAL_W + 1;
   localparam int DCW = $clog2(NW) + 1;
   localparam int PW  = 3 * CB;

   logic [PW-1:0]    pos_mem [MAX_ATOMS];
   logic [CNT_W-1:0] cnt_mem [MAX_ATOMS];

   logic [NW-1:0]    loaded_ff, loaded_in;
   logic [NW-1:0]    n_ff, n_in;
   logic [NW-1:0]    last_n_ff, last_n_in;
   logic [IW-1:0]    k_ff, k_in;
   logic [IW-1:0]    i_ff, i_in;
   logic [IW-1:0]    j_ff, j_in;
   logic [IW-1:0]    i_end_ff, i_end_in;
   logic [TOTAL_W-1:0] step_ff, step_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [DCW-1:0]   dcnt_ff, dcnt_in;
   logic [NW+RANK_W-1:0]  start_p_ff;
   logic [NW+RANK_W:0]    end_p_ff;
   logic [SQW-1:0]   cut_sq_ff;
   logic [PW-1:0]    pos_rd_ff;
   logic [CNT_W-1:0] cnt_rd_ff;
   logic [PW-1:0]    pos_i_ff;
   logic [CNT_W-1:0] cnt_i_ff, cnt_i_in;
   logic [CUT_W-1:0] mag_ff [3];
   logic             fail_ff;
   logic [SQW-1:0]   sq_ff [3];
   logic             fail_sq_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic             rsp_done_ff;
   logic             rd_ok_ff;

   logic [TOTAL_W-1:0] tot;
   logic [XW-1:0]    idx_x;
   logic [RW-1:0]    rem_sh;
   logic             rem_ge;
   logic             pos_re, cnt_re;
   logic [AW-1:0]    pos_ra, cnt_ra;
   logic             cnt_we;
   logic [AW-1:0]    cnt_wa;
   logic [CNT_W-1:0] cnt_wd;
   logic             hit;
   logic [SMW-1:0]   sum_sq;
   logic [IW-1:0]    j_next;
   logic [IW-1:0]    s_clamp, e_clamp;
   logic [MW-1:0]    mag_w [3];
   logic             fail_w [3];

   assign tot   = (cfg.worker_total == '0) ? TOTAL_W'(1) : cfg.worker_total;
   assign idx_x = XW'(read_index);

   // Restoring division of the atom count by the worker total, one quotient bit a cycle.
   assign rem_sh = {rem_ff[RW-2:0], quo_ff[NW-1]};
   assign rem_ge = rem_sh >= RW'(tot);

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_init) begin
         rem_in  = '0;
         quo_in  = n_ff;
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = rem_ge ? rem_sh - RW'(tot) : rem_sh;
         quo_in  = {quo_ff[NW-2:0], rem_ge};
         dcnt_in = dcnt_ff + DCW'(1);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [CB:0] d;
         logic [CB:0]        m;
         d = $signed({pos_i_ff[k*CB+CB-1], pos_i_ff[k*CB +: CB]})
           - $signed({pos_rd_ff[k*CB+CB-1], pos_rd_ff[k*CB +: CB]});
         m = d[CB] ? (CB+1)'(-d) : (CB+1)'(d);
         mag_w[k]  = MW'(m);
         fail_w[k] = mag_w[k] >= MW'(cfg.cut_dist);
      end
   end

   assign sum_sq = SMW'(sq_ff[0]) + SMW'(sq_ff[1]) + SMW'(sq_ff[2]);
   assign hit    = !fail_sq_ff && (sum_sq < SMW'(cut_sq_ff));
   assign j_next = j_ff + IW'(1);

   assign s_clamp = (start_p_ff > (NW+RANK_W)'(n_ff)) ? IW'(n_ff) : IW'(start_p_ff);
   assign e_clamp = (RW'(cfg.worker_rank) == RW'(tot) - RW'(1) ||
                     end_p_ff > (NW+RANK_W+1)'(n_ff)) ? IW'(n_ff) : IW'(end_p_ff);

   always_comb begin
      loaded_in = loaded_ff;
      n_in      = n_ff;
      last_n_in = last_n_ff;
      if (load_acc) begin
         if (run_go) begin
            loaded_in = '0;
            n_in      = (loaded_ff < NW'(MAX_ATOMS)) ? loaded_ff + NW'(1) : loaded_ff;
            last_n_in = n_in;
         end else if (loaded_ff < NW'(MAX_ATOMS)) begin
            loaded_in = loaded_ff + NW'(1);
         end
      end
   end

   always_comb begin
      k_in     = cmd.clr_wr ? k_ff + IW'(1) : (run_go ? '0 : k_ff);
      i_in     = i_ff;
      i_end_in = i_end_ff;
      step_in  = step_ff;
      j_in     = j_ff;
      if (cmd.bnd_set) begin
         if (cfg.share_mode) begin
            i_in     = IW'(cfg.worker_rank);
            step_in  = tot;
            i_end_in = IW'(n_ff);
         end else begin
            i_in     = s_clamp;
            step_in  = TOTAL_W'(1);
            i_end_in = e_clamp;
         end
      end else if (cmd.row_end) begin
         i_in = i_ff + IW'(step_ff);
      end
      if (cmd.row_rd) begin
         j_in = i_ff + IW'(1);
      end else if (cmd.pair_cmp) begin
         j_in = j_next;
      end
   end

   always_comb begin
      cnt_i_in = cnt_i_ff;
      if (cmd.row_lat) begin
         cnt_i_in = cnt_rd_ff;
      end else if (cmd.pair_cmp && hit && cnt_i_ff != CNT_MAX) begin
         cnt_i_in = cnt_i_ff + CNT_W'(1);
      end
   end

   always_comb begin
      pos_re = cmd.row_rd || cmd.pair_rd;
      pos_ra = cmd.row_rd ? i_ff[AW-1:0] : j_ff[AW-1:0];
      cnt_re = read_acc || cmd.row_rd || cmd.pair_rd;
      cnt_ra = read_acc ? idx_x[AW-1:0] : pos_ra;
      cnt_we = 1'b0;
      cnt_wa = k_ff[AW-1:0];
      cnt_wd = '0;
      if (cmd.clr_wr) begin
         cnt_we = 1'b1;
      end else if (cmd.pair_cmp && hit) begin
         cnt_we = 1'b1;
         cnt_wa = j_ff[AW-1:0];
         cnt_wd = (cnt_rd_ff == CNT_MAX) ? cnt_rd_ff : cnt_rd_ff + CNT_W'(1);
      end else if (cmd.row_end) begin
         cnt_we = 1'b1;
         cnt_wa = i_ff[AW-1:0];
         cnt_wd = cnt_i_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_acc && loaded_ff < NW'(MAX_ATOMS)) begin
         pos_mem[loaded_ff[AW-1:0]] <= {pos_z, pos_y, pos_x};
      end
      if (pos_re) begin
         pos_rd_ff <= pos_mem[pos_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[cnt_ra];
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      k_ff     <= k_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      i_end_ff <= i_end_in;
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dcnt_ff  <= dcnt_in;
      cnt_i_ff <= cnt_i_in;
      if (cmd.bnd_mul) begin
         start_p_ff <= (NW+RANK_W)'(quo_ff) * (NW+RANK_W)'(cfg.worker_rank);
         end_p_ff   <= (NW+RANK_W+1)'(quo_ff) *
                       (NW+RANK_W+1)'({1'b0, cfg.worker_rank} + (RANK_W+1)'(1));
         cut_sq_ff  <= SQW'(cfg.cut_dist) * SQW'(cfg.cut_dist);
      end
      if (cmd.row_lat) begin
         pos_i_ff <= pos_rd_ff;
      end
      if (cmd.pair_diff) begin
         for (int k = 0; k < 3; k++) begin
            mag_ff[k] <= mag_w[k][CUT_W-1:0];
         end
         fail_ff <= fail_w[0] || fail_w[1] || fail_w[2];
      end
      if (cmd.pair_sq) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= SQW'(mag_ff[k]) * SQW'(mag_ff[k]);
         end
         fail_sq_ff <= fail_ff;
      end
      if (read_acc) begin
         rsp_idx_ff <= read_index;
         rd_ok_ff   <= idx_x < XW'(last_n_ff);
      end
      if (read_acc || cmd.done) begin
         rsp_done_ff <= cmd.done;
      end
      if (cmd.done) begin
         rsp_idx_ff <= '0;
         rd_ok_ff   <= 1'b0;
      end
   end

   assign rsp_valid_in = read_acc || cmd.done;

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         last_n_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         last_n_ff    <= last_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.clr_last = (k_ff == IW'(n_ff) - IW'(1));
   assign status.div_last = (dcnt_ff == DCW'(NW - 1));
   assign status.row_over = (i_ff >= i_end_ff);
   assign status.j_over   = (j_ff >= IW'(n_ff));
   assign status.j_last   = (j_next >= IW'(n_ff));

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_atom_index      = rsp_idx_ff;
   assign rsp_neighbour_count = rd_ok_ff ? cnt_rd_ff : '0;
   assign rsp_run_done        = rsp_done_ff;

`ifndef SYNTHESIS
   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= NW'(MAX_ATOMS))
      else $error("load count beyond store depth");
   a_go_resets_load: assert property (@(posedge clock) disable iff (reset)
      run_go |=> loaded_ff == '0)
      else $error("final load did not restart the batch");
   a_pair_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.pair_rd |-> (j_ff < IW'(n_ff) && j_ff > i_ff))
      else $error("pair column out of range");
`endif

endmodule

>>> hdl/pairwise_neighbour_counter.sv
// Channel   Handshake             Payload
// req       start / busy          req_op, req_pos_x/y/z, req_final_atom, req_read_index
// rsp       rsp_valid strobe      rsp_atom_index, rsp_neighbour_count, rsp_run_done
// csr       csr_valid / csr_ready csr_index, csr_wdata
//
// Loads and reads are taken one per cycle while busy is low; a read's result follows on the next cycle.
// A final load holds busy while the count memory is cleared (one entry per atom loaded),
// the atom count is divided by the worker total bit by bit and the row bounds are set up,
// then each row is checked, read and written back and each pair is read, differenced,
// squared and compared; the run-done result is on the first cycle with busy low again.
// Reset is synchronous and restores the default configuration with an empty batch; the
// receiver cannot stall and csr_ready is always high.
module pairwise_neighbour_counter #(
   parameter int MAX_ATOMS  = 16384,
   parameter int COORD_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic signed [COORD_BITS-1:0]       req_pos_x,
   input  logic signed [COORD_BITS-1:0]       req_pos_y,
   input  logic signed [COORD_BITS-1:0]       req_pos_z,
   input  logic                               req_final_atom,
   input  logic [pnc_pkg::IDX_W-1:0]          req_read_index,
   output logic                               rsp_valid,
   output logic [pnc_pkg::IDX_W-1:0]          rsp_atom_index,
   output logic [pnc_pkg::CNT_W-1:0]          rsp_neighbour_count,
   output logic                               rsp_run_done,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pnc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pnc_pkg::CUT_W-1:0]          csr_wdata
);
   import pnc_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       acc;
   logic       load_acc;
   logic       read_acc;
   logic       run_go;

   assign acc       = start && !busy;
   assign load_acc  = acc && !req_op;
   assign read_acc  = acc && req_op;
   assign run_go    = load_acc && req_final_atom;
   assign csr_ready = 1'b1;

   pnc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pnc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .run_go (run_go),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   pnc_dp #(
      .MAX_ATOMS  (MAX_ATOMS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .status              (status),
      .load_acc            (load_acc),
      .read_acc            (read_acc),
      .run_go              (run_go),
      .pos_x               (req_pos_x),
      .pos_y               (req_pos_y),
      .pos_z               (req_pos_z),
      .read_index          (req_read_index),
      .rsp_valid           (rsp_valid),
      .rsp_atom_index      (rsp_atom_index),
      .rsp_neighbour_count (rsp_neighbour_count),
      .rsp_run_done        (rsp_run_done)
   );

endmodule

>>> test/pairwise_neighbour_counter_tb.sv
`timescale 1ns / 100ps

module pairwise_neighbour_counter_tb;
   import pnc_pkg::*;

   localparam int ATOMS = 16384;
   localparam int CB    = 24;

   typedef struct {
      logic                 op;
      logic signed [CB-1:0] x, y, z;
      logic                 fin;
      logic [IDX_W-1:0]     ridx;
   } atom_req_type;

   typedef struct {
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] cnt;
      logic             done;
   } count_rsp_type;

   logic clock = 0, reset = 1;
   logic start = 0, busy;
   logic req_op = 0, req_final_atom = 0;
   logic signed [CB-1:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic [IDX_W-1:0] req_read_index = 0;
   logic rsp_valid, rsp_run_done;
   logic [IDX_W-1:0] rsp_atom_index;
   logic [CNT_W-1:0] rsp_neighbour_count;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SHARE_MODE;
   logic [CUT_W-1:0] csr_wdata = 0;

   pairwise_neighbour_counter dut (.*);

   always #5 clock = ~clock;

   // Predictor state
   int               atom_xyz [ATOMS][3];
   logic [CNT_W-1:0] atom_counts [ATOMS];
   int unsigned      batch_len;
   logic             cfg_share;
   logic [RANK_W-1:0]  cfg_rank;
   logic [TOTAL_W-1:0] cfg_total;
   logic [CUT_W-1:0]   cfg_cut;

   atom_req_type  pending_reqs[$];
   count_rsp_type awaited_counts[$];
   atom_req_type  cur_req;
   bit         took_req;
   bit         calm;
   int         mismatches, matched, runs_seen;

   function automatic bit within_cutoff(int a, int b);
      longint unsigned c = cfg_cut, sum = 0, m;
      longint d;
      for (int k = 0; k < 3; k++) begin
         d = longint'(atom_xyz[a][k]) - longint'(atom_xyz[b][k]);
         m = d < 0 ? -d : d;
         if (m >= c) return 0;
         sum += m * m;
      end
      return sum < c * c;
   endfunction

   function automatic void count_row(int unsigned i, int unsigned n);
      for (int unsigned j = i + 1; j < n; j++)
         if (within_cutoff(i, j)) begin
            if (atom_counts[i] != CNT_MAX) atom_counts[i]++;
            if (atom_counts[j] != CNT_MAX) atom_counts[j]++;
         end
   endfunction

   function automatic void count_batch(int unsigned n);
      int unsigned tot = cfg_total == 0 ? 1 : cfg_total;
      int unsigned chunk, lo, hi;
      foreach (atom_counts[k]) atom_counts[k] = 0;
      if (cfg_share) begin
         for (int unsigned i = cfg_rank; i < n; i += tot) count_row(i, n);
      end else begin
         chunk = n / tot;
         lo = chunk * cfg_rank;
         hi = chunk * (cfg_rank + 1);
         if (cfg_rank == tot - 1) hi = n;
         if (lo > n) lo = n;
         if (hi > n) hi = n;
         for (int unsigned i = lo; i < hi; i++) count_row(i, n);
      end
   endfunction

   function automatic void predict_counts(atom_req_type r);
      count_rsp_type e;
      if (r.op) begin
         e.idx = r.ridx; e.cnt = atom_counts[r.ridx]; e.done = 0;
         awaited_counts.insert(awaited_counts.size(), e);
         return;
      end
      if (batch_len < ATOMS) begin
         atom_xyz[batch_len][0] = r.x;
         atom_xyz[batch_len][1] = r.y;
         atom_xyz[batch_len][2] = r.z;
         batch_len++;
      end
      if (r.fin) begin
         count_batch(batch_len);
         batch_len = 0;
         e.idx = 0; e.cnt = 0; e.done = 1;
         awaited_counts.insert(awaited_counts.size(), e);
      end
   endfunction

   // Acceptance is observed at the rising edge; the next item is driven at the falling edge.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         predict_counts(cur_req);
         took_req = 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (!start || took_req) begin
         took_req = 0;
         if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
            cur_req = pending_reqs.pop_front();
            req_op <= cur_req.op;
            req_pos_x <= cur_req.x;
            req_pos_y <= cur_req.y;
            req_pos_z <= cur_req.z;
            req_final_atom <= cur_req.fin;
            req_read_index <= cur_req.ridx;
            start <= 1;
         end else begin
            start <= 0;
         end
      end
   end

   always @(posedge clock) begin
      count_rsp_type e;
      if (!reset && rsp_valid) begin
         if (awaited_counts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: atom %0d count %0d done %0b",
                        rsp_atom_index, rsp_neighbour_count, rsp_run_done);
         end else begin
            e = awaited_counts.pop_front();
            if (e.idx !== rsp_atom_index || e.cnt !== rsp_neighbour_count
                || e.done !== rsp_run_done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected atom %0d count %0d done %0b, got %0d %0d %0b",
                           e.idx, e.cnt, e.done, rsp_atom_index, rsp_neighbour_count,
                           rsp_run_done);
            end else begin
               matched++;
               if (e.done) runs_seen++;
            end
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CUT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SHARE_MODE:   cfg_share = val[0];
         CSR_WORKER_RANK:  cfg_rank  = val[RANK_W-1:0];
         CSR_WORKER_TOTAL: cfg_total = val[TOTAL_W-1:0];
         CSR_CUTOFF:       cfg_cut   = val;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic apply_setting(bit sm, int rk, int tot, int cut);
      write_csr(CSR_SHARE_MODE, sm);
      write_csr(CSR_WORKER_RANK, rk);
      write_csr(CSR_WORKER_TOTAL, tot);
      write_csr(CSR_CUTOFF, cut);
   endtask

   // The sender holds off until every expected result has come back.
   task automatic drain();
      while (pending_reqs.size() > 0 || start || awaited_counts.size() > 0 || busy)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic push_load(int x, int y, int z, bit fin);
      atom_req_type r;
      r.op = 0; r.x = x; r.y = y; r.z = z; r.fin = fin; r.ridx = $urandom;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic push_read(int idx, bit fin);
      atom_req_type r;
      r.op = 1; r.x = $urandom; r.y = $urandom; r.z = $urandom; r.fin = fin; r.ridx = idx;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic random_batch(int n);
      int c = cfg_cut == 0 ? 4096 : cfg_cut;
      int bx = $urandom, by = $urandom, bz = $urandom;
      for (int k = 0; k < n; k++)
         if ($urandom_range(7) == 0 || cfg_cut > 2000000)
            push_load($urandom, $urandom, $urandom, k == n - 1);
         else
            push_load(bx + $urandom_range(2 * c) - c, by + $urandom_range(2 * c) - c,
                      bz + $urandom_range(2 * c) - c, k == n - 1);
      for (int k = 0; k < n + 2; k++)
         push_read(k < n ? k : $urandom_range(ATOMS - 1), $urandom_range(1));
   endtask

   initial begin
      int n;
      cfg_share = 1; cfg_rank = 0; cfg_total = 1; cfg_cut = 32768;
      batch_len = 0;
      foreach (atom_counts[k]) atom_counts[k] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: reads before any run, extremes, the cutoff boundary on each side.
      push_read(0, 0);
      push_read(ATOMS - 1, 1);
      push_load(0, 0, 0, 0);
      push_load(32767, 0, 0, 0);
      push_load(0, -32768, 0, 0);
      push_load(0, 0, 23170, 0);
      push_load(8388607, 8388607, 8388607, 0);
      push_load(-8388608, -8388608, -8388608, 0);
      push_load(8388607, 8388607, 8388606, 1);
      for (int k = 0; k < 8; k++) push_read(k, k[0]);
      push_load(5, 5, 5, 1);   // batch of one atom
      push_read(0, 0);
      drain();

      apply_setting(0, 0, 1, 0);
      push_load(0, 0, 0, 0);
      push_load(0, 0, 0, 1);
      push_read(0, 0);
      push_read(1, 0);
      drain();

      for (int s = 0; s < 12; s++) begin
         case (s)
            0:  apply_setting(1, 0, 1, 8388607);
            1:  apply_setting(0, 1, 3, $urandom_range(4096, 100000));
            2:  apply_setting(0, 2, 3, $urandom_range(4096, 100000));
            3:  apply_setting(1, 2, 3, $urandom_range(4096, 100000));
            4:  apply_setting(1, 63, 64, $urandom_range(4096, 100000));
            5:  apply_setting(0, 63, 64, $urandom_range(4096, 100000));
            6:  apply_setting(1, 5, 0, $urandom_range(4096, 100000));
            7:  apply_setting(0, 0, 0, $urandom_range(1, 8388607));
            8:  apply_setting(0, 4, 2, $urandom_range(4096, 100000));
            9:  apply_setting(1, 9, 4, $urandom_range(4096, 100000));
            10: apply_setting(0, 1, 2, $urandom_range(100, 300000));
            default: apply_setting(1, 0, 1, $urandom_range(4096, 100000));
         endcase
         calm = (s == 3);
         for (int b = 0; b < 2; b++) begin
            n = $urandom_range(7) == 0 ? 48 : $urandom_range(2, 20);
            random_batch(n);
         end
         drain();
      end
      calm = 0;

      // The rank lies past the only chunk, so no rows run.
      apply_setting(0, 5, 1, 32768);
      random_batch(6);
      drain();
      apply_setting(1, 0, 1, 32768);
      random_batch(6);
      drain();

      repeat (20) @(posedge clock);
      $display("Covered %0d matched results over %0d counting runs, all share modes,",
               matched, runs_seen);
      $display("rank and total corners, cutoff zero and maximum, and a rank past every chunk.");
      if (mismatches == 0 && awaited_counts.size() == 0)
         $display("pairwise_neighbour_counter_tb: PASS");
      else
         $display("pairwise_neighbour_counter_tb: FAIL");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("pairwise_neighbour_counter_tb: FAIL");
      $finish;
   end

endmodule
